@@ rtl/core/ntm_pkg.sv @@
// Shared types and constants for the normalized two-track mixer.
// No dependencies; imported by ntm_ctrl, ntm_dp and the top level.
package ntm_pkg;

  localparam int GainW    = 7;
  localparam int SampW    = 8;
  localparam int MixW     = 16;
  localparam int PeakW    = 15;
  localparam int ScaleW   = 24;
  localparam int ProdW    = ScaleW + 1 + MixW;
  localparam int DivSteps = ScaleW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int InDataW  = 24;
  localparam int FracW    = 16;

  localparam logic [ScaleW-1:0] Dividend   = 24'h800000;
  localparam logic [SampW-1:0]  MixOffset  = 8'h80;
  localparam logic [GainW-1:0]  GainReset  = 7'd50;
  localparam logic signed [SampW-1:0] SatMax = 8'sd127;
  localparam logic signed [SampW-1:0] SatMin = -8'sd128;

  // register indexes on the config port
  localparam logic RegGainOrig = 1'b0;
  localparam logic RegGainClip = 1'b1;

  typedef struct packed {
    logic load_in;   // input transfer this cycle
    logic upd_peak;  // fold |mix| into the running peak
    logic div_init;  // seed the divider
    logic div_step;  // one quotient bit
    logic mul;       // scale * mix
    logic out_load;  // move the saturated result to the output register
  } ntm_cmd_t;

  typedef struct packed {
    logic last;      // last flag of the held item
    logic div_last;  // divider on its final step
    logic out_free;  // output register can take a result
  } ntm_stat_t;

endpackage

@@ rtl/core/ntm_ctrl.sv @@
// Sequencer for the mixer: input acceptance, peak/divide and apply steps.
// Depends on ntm_pkg (command and status structs).
module ntm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_pass,
  output logic               in_ready,
  input  ntm_pkg::ntm_stat_t st,
  output ntm_pkg::ntm_cmd_t  cmd
);
  import ntm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PEAK, S_DIV, S_MUL, S_SAT} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_pass ? S_MUL : S_PEAK;
        end
      end
      S_PEAK: begin
        cmd.upd_peak = 1'b1;
        if (st.last) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("ready raised outside idle");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !st.div_last) |=> state_r == S_DIV)
    else $error("divide left early");

  a_sat_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SAT && !st.out_free) |=> state_r == S_SAT)
    else $error("result dropped while output busy");

endmodule

@@ rtl/core/ntm_dp.sv @@
// Datapath: gain registers, weighted mix, peak tracking, restoring divider,
// scale multiply, round-toward-zero shift, saturation and output register.
// Depends on ntm_pkg.
module ntm_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ntm_pkg::GainW-1:0]   cfg_wdata,
  input  logic                        in_last,
  input  logic signed [ntm_pkg::SampW-1:0] in_orig,
  input  logic [ntm_pkg::SampW-1:0]   in_clip,
  input  logic                        in_clip_present,
  input  ntm_pkg::ntm_cmd_t           cmd,
  output ntm_pkg::ntm_stat_t          st,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ntm_pkg::SampW-1:0]   out_data,
  output logic                        out_last
);
  import ntm_pkg::*;

  logic [GainW-1:0]         gain_orig_r, gain_clip_r;
  logic signed [MixW-1:0]   mix_r, mix_nxt;
  logic                     last_r;
  logic [PeakW-1:0]         peak_r, peak_nxt;
  logic [MixW-1:0]          mag;
  logic [PeakW-1:0]         rem_r, rem_nxt;
  logic [ScaleW-1:0]        dvd_r, quot_r, quot_nxt;
  logic [DivCntW-1:0]       div_cnt_r;
  logic [MixW-1:0]          rem_sh;
  logic [MixW:0]            diff;
  logic                     div_fin;
  logic [ScaleW-1:0]        scale_r;
  logic signed [ProdW-1:0]  prod_r, prod_nxt, prod_adj;
  logic signed [ProdW-FracW-1:0] quo;
  logic [SampW-1:0]         out_data_r, out_data_nxt;
  logic                     out_valid_r, out_last_r;
  logic signed [SampW-1:0]  clip_s;

  // clip byte minus offset is the byte with its top bit flipped
  assign clip_s  = in_clip_present ? $signed(in_clip ^ MixOffset) : '0;
  assign mix_nxt = $signed({1'b0, gain_orig_r}) * in_orig
                 + $signed({1'b0, gain_clip_r}) * clip_s;

  assign mag = mix_r[MixW-1] ? MixW'(-mix_r) : mix_r;

  always_comb begin
    peak_nxt = peak_r;
    if (cmd.upd_peak && (mag > {1'b0, peak_r})) peak_nxt = mag[PeakW-1:0];
  end

  // restoring divide, one quotient bit per cycle
  assign rem_sh   = {rem_r, dvd_r[ScaleW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, peak_r};
  assign rem_nxt  = diff[MixW] ? rem_sh[PeakW-1:0] : diff[PeakW-1:0];
  assign quot_nxt = {quot_r[ScaleW-2:0], ~diff[MixW]};
  assign div_fin  = cmd.div_step && (div_cnt_r == DivCntW'(DivSteps - 1));

  assign prod_nxt = $signed({1'b0, scale_r}) * mix_r;
  // bias negatives so the arithmetic shift truncates toward zero
  assign prod_adj = prod_r + (prod_r[ProdW-1] ? ProdW'((1 << FracW) - 1) : '0);
  assign quo      = prod_adj[ProdW-1:FracW];

  always_comb begin
    if (quo > ProdW'(SatMax))      out_data_nxt = SatMax;
    else if (quo < ProdW'(SatMin)) out_data_nxt = SatMin;
    else                           out_data_nxt = quo[SampW-1:0];
  end

  assign st.last     = last_r;
  assign st.div_last = (div_cnt_r == DivCntW'(DivSteps - 1));
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_orig_r <= GainReset;
      gain_clip_r <= GainReset;
      peak_r      <= '0;
      scale_r     <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegGainOrig) gain_orig_r <= cfg_wdata;
        if (cfg_index == RegGainClip) gain_clip_r <= cfg_wdata;
      end
      if (div_fin) begin
        scale_r <= (peak_r == '0) ? '0 : quot_nxt;
        peak_r  <= '0;
      end else begin
        peak_r <= peak_nxt;
      end
      if (cmd.div_init)      div_cnt_r <= '0;
      else if (cmd.div_step) div_cnt_r <= div_cnt_r + 1'b1;
      if (cmd.out_load)      out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mix_r  <= mix_nxt;
      last_r <= in_last;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      dvd_r  <= Dividend;
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[ScaleW-2:0], 1'b0};
      quot_r <= quot_nxt;
    end
    if (cmd.mul) prod_r <= prod_nxt;
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= last_r;
    end
  end

  a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    div_fin |=> peak_r == '0)
    else $error("peak not cleared after divide");

  a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (div_fin && peak_r != '0) |->
      (40'(quot_nxt) * 40'(peak_r) <= 40'(Dividend)) &&
      (40'(Dividend) - 40'(quot_nxt) * 40'(peak_r) < 40'(peak_r)))
    else $error("divider quotient wrong");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid_r) |-> out_ready)
    else $error("output overwritten before transfer");

endmodule

@@ rtl/core/normalized_two_track_mixer.sv @@
// Top level of the peak-normalized two-track mixer.
// Depends on ntm_pkg, ntm_ctrl and ntm_dp.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata orig,clip,present; tuser pass; tlast
//  out_     master     out_tvalid/out_tready tdata mixed sample; tlast
//  cfg_     write      cfg_we               cfg_index, cfg_wdata (gain registers)
//
// Measure-pass item: input and peak steps; its last item adds a restoring divide.
// Apply-pass item: mix, multiply, then shift and saturate; a held output
// register stalls only the final step.
// Synchronous active-low reset; no clearing pass. Gains reset to 50, peak and
// scale to zero.
module normalized_two_track_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ntm_pkg::GainW-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] orig_sample, [15:8] clip_byte, [16] clip_present, rest zero
  input  logic [ntm_pkg::InDataW-1:0]    in_tdata,
  // [0] pass_sel
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] mixed_sample
  output logic [ntm_pkg::SampW-1:0]      out_tdata,
  output logic                           out_tlast
);
  import ntm_pkg::*;

  ntm_cmd_t  cmd;
  ntm_stat_t st;

  ntm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_pass  (in_tuser),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ntm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_last         (in_tlast),
    .in_orig         ($signed(in_tdata[SampW-1:0])),
    .in_clip         (in_tdata[2*SampW-1:SampW]),
    .in_clip_present (in_tdata[2*SampW]),
    .cmd             (cmd),
    .st              (st),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_data        (out_tdata),
    .out_last        (out_tlast)
  );

endmodule
